[rtl/core/set_assoc_lru_cache_tags_defines.svh]
// Assertion macros for the cache tag store
`ifndef SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SALC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define SALC_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SALC_ASSERT(label, clk, rst, prop)
`define SALC_ASSERT_NR(label, clk, prop)
`endif
`endif

[rtl/core/salc_pkg.sv]
// Shared types and constants for the cache tag store
package salc_pkg;
  localparam int DEF_MAX_SET_BITS = 8;
  localparam int DEF_MAX_WAYS = 8;
  localparam int DEF_ADDR_BITS = 32;
  localparam int CNT_BITS = 32;

  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_WAYS = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_WRITE
  } bk_state_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic evicted;
    logic [CNT_BITS-1:0] hit_total;
    logic [CNT_BITS-1:0] miss_total;
    logic [CNT_BITS-1:0] evict_total;
  } result_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction
endpackage

[rtl/core/salc_if.sv]
// Valid/ready channel interfaces for access, result and register write beats
interface salc_access_if #(parameter int ADDR_BITS = 32);
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [ADDR_BITS-1:0] address;
  modport source (output valid, operation, address, input ready);
  modport sink (input valid, operation, address, output ready);
endinterface

interface salc_result_if;
  logic valid;
  logic ready;
  logic hit;
  logic miss;
  logic evicted;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] evict_total;
  modport source (output valid, hit, miss, evicted, hit_total, miss_total, evict_total,
                  input ready);
  modport sink (input valid, hit, miss, evicted, hit_total, miss_total, evict_total,
                output ready);
endinterface

interface salc_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/set_assoc_lru_cache_tags.sv]
// Set-associative tag store with true LRU replacement: each access passes the
// back end steps (set read, reorder and write back, return to idle) on the
// single-port set memory, and no new access is taken until the last is
// written back and the result register is free; a two-entry queue decouples
// the address front end. After reset all 2**MAX_SET_BITS sets are cleared first.
module set_assoc_lru_cache_tags #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS
) (
  input logic clk,
  input logic rst,
  salc_cfg_if.sink cfg,
  salc_access_if.sink acc,
  salc_result_if.source res
);
  import salc_pkg::*;
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  logic [3:0] set_bits, ways;
  logic [4:0] block_bits;
  logic q_valid, q_ready, q_modify;
  logic [SET_W-1:0] q_set;
  logic [ADDR_BITS-1:0] q_tag;
  result_t out_res;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= 4'd4;
      ways <= 4'd1;
      block_bits <= 5'd4;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SET_BITS: set_bits <= cfg.data[3:0];
        REG_WAYS: ways <= cfg.data[3:0];
        REG_BLOCK_BITS: block_bits <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  salc_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_BITS(ADDR_BITS)) u_front (
    .clk, .rst, .set_bits, .block_bits,
    .in_valid(acc.valid), .in_ready(acc.ready), .in_op(acc.operation),
    .in_addr(acc.address),
    .q_valid, .q_ready, .q_modify, .q_set, .q_tag
  );

  salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS))
  u_back (
    .clk, .rst, .ways, .q_valid, .q_ready, .q_modify, .q_set, .q_tag,
    .out_valid(res.valid), .out_ready(res.ready), .out_res
  );

  assign res.hit = out_res.hit;
  assign res.miss = out_res.miss;
  assign res.evicted = out_res.evicted;
  assign res.hit_total = out_res.hit_total;
  assign res.miss_total = out_res.miss_total;
  assign res.evict_total = out_res.evict_total;
endmodule

[rtl/core/salc_front.sv]
// Front end: splits addresses into set index and tag, queues classified accesses
module salc_front #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS,
  parameter int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic [3:0] set_bits,
  input  logic [4:0] block_bits,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_op,
  input  logic [ADDR_BITS-1:0] in_addr,
  output logic q_valid,
  input  logic q_ready,
  output logic q_modify,
  output logic [SET_W-1:0] q_set,
  output logic [ADDR_BITS-1:0] q_tag
);
  import salc_pkg::*;
  localparam int SB_W = $clog2(ADDR_BITS + 1);
  localparam int ENT_W = 1 + SET_W + ADDR_BITS;

  logic [SB_W-1:0] s_eff, b_eff, sb;
  logic [ADDR_BITS-1:0] shifted, idx_mask, tag_mask;
  logic [SET_W-1:0] set_idx;
  logic [ENT_W-1:0] ent [2];
  logic [1:0] count;
  logic wr_ptr, rd_ptr;
  logic push, pop;

  always_comb begin
    s_eff = (SB_W'(set_bits) > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits);
    if (s_eff > SB_W'(ADDR_BITS)) s_eff = SB_W'(ADDR_BITS);
    b_eff = (SB_W'(block_bits) > SB_W'(ADDR_BITS) - s_eff) ?
            SB_W'(ADDR_BITS) - s_eff : SB_W'(block_bits);
    sb = s_eff + b_eff;
    shifted = in_addr >> b_eff;
    idx_mask = ~({ADDR_BITS{1'b1}} << s_eff);
    if (s_eff == SB_W'(ADDR_BITS)) idx_mask = '1;
    tag_mask = {ADDR_BITS{1'b1}} << sb;
    if (sb == SB_W'(ADDR_BITS)) tag_mask = '0;
    set_idx = SET_W'(shifted & idx_mask);
    if (MAX_SET_BITS == 0) set_idx = '0;
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign {q_modify, q_set, q_tag} = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= {in_op == OP_MODIFY, set_idx, in_addr & tag_mask};
    if (rst) begin
      count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/core/salc_back.sv]
// Back end: set read, LRU reorder and write back, counters and result register
`include "set_assoc_lru_cache_tags_defines.svh"
module salc_back #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS,
  parameter int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic [3:0] ways,
  input  logic q_valid,
  output logic q_ready,
  input  logic q_modify,
  input  logic [SET_W-1:0] q_set,
  input  logic [ADDR_BITS-1:0] q_tag,
  output logic out_valid,
  input  logic out_ready,
  output salc_pkg::result_t out_res
);
  import salc_pkg::*;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int LINE_W = ADDR_BITS + 1;
  localparam int ROW_W = MAX_WAYS * LINE_W;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W = $clog2(MAX_WAYS + 1);

  logic [ROW_W-1:0] mem [NUM_SETS];
  logic [ROW_W-1:0] rd_row, new_row;
  logic [SET_W-1:0] clr_addr, cur_set;
  logic [ADDR_BITS-1:0] cur_tag;
  logic cur_mod;
  bk_state_t state, state_next;
  logic [CNT_BITS-1:0] hit_count, miss_count, evict_count;
  logic [WC_W-1:0] w_eff;
  logic found, ev;
  logic [WAY_W-1:0] pos, last;
  logic [LINE_W-1:0] mover;

  always_comb begin
    w_eff = WC_W'(MAX_WAYS);
    if (ways == 4'd0) w_eff = WC_W'(1);
    else if ({28'd0, ways} < MAX_WAYS) w_eff = WC_W'(ways);
    last = WAY_W'(w_eff - WC_W'(1));
    found = 1'b0;
    pos = last;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (i < int'(w_eff) && rd_row[i*LINE_W + ADDR_BITS] &&
          rd_row[i*LINE_W +: ADDR_BITS] == cur_tag) begin
        found = 1'b1;
        pos = WAY_W'(i);
      end
    end
    ev = !found && rd_row[int'(last)*LINE_W + ADDR_BITS];
    mover = found ? rd_row[int'(pos)*LINE_W +: LINE_W] : {1'b1, cur_tag};
    new_row = rd_row;
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (j <= int'(pos)) new_row[j*LINE_W +: LINE_W] = rd_row[(j-1)*LINE_W +: LINE_W];
    end
    new_row[0 +: LINE_W] = mover;
  end

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    case (state)
      BK_CLEAR: if (clr_addr == SET_W'(NUM_SETS - 1)) state_next = BK_IDLE;
      BK_IDLE: begin
        q_ready = !out_valid || out_ready;
        if (q_valid && q_ready) state_next = BK_READ;
      end
      BK_READ: state_next = BK_WRITE;
      BK_WRITE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == BK_CLEAR) mem[clr_addr] <= '0;
    else if (state == BK_WRITE) mem[cur_set] <= new_row;
    if (state == BK_IDLE) rd_row <= mem[q_set];
    if (q_valid && q_ready) begin
      cur_set <= q_set;
      cur_tag <= q_tag;
      cur_mod <= q_modify;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_WRITE) begin
      out_res.hit <= found;
      out_res.miss <= !found;
      out_res.evicted <= ev;
      out_res.hit_total <= (found && cur_mod) ? sat_inc(sat_inc(hit_count)) :
                           (found || cur_mod) ? sat_inc(hit_count) : hit_count;
      out_res.miss_total <= found ? miss_count : sat_inc(miss_count);
      out_res.evict_total <= ev ? sat_inc(evict_count) : evict_count;
    end
    if (rst) begin
      state <= BK_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      hit_count <= '0;
      miss_count <= '0;
      evict_count <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == BK_WRITE) begin
        out_valid <= 1'b1;
        hit_count <= (found && cur_mod) ? sat_inc(sat_inc(hit_count)) :
                     (found || cur_mod) ? sat_inc(hit_count) : hit_count;
        if (!found) miss_count <= sat_inc(miss_count);
        if (ev) evict_count <= sat_inc(evict_count);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SALC_ASSERT(a_read_then_write, clk, rst, state == BK_READ |=> state == BK_WRITE)
  `SALC_ASSERT(a_no_take_when_busy, clk, rst, state != BK_IDLE |-> !q_ready)
  `SALC_ASSERT(a_result_after_write, clk, rst, state == BK_WRITE |=> out_valid)
  `SALC_ASSERT(a_miss_counts, clk, rst,
    (state == BK_WRITE && !found && miss_count != '1) |=>
      miss_count == $past(miss_count) + 1'b1)
endmodule
